// File: rtl/fbfl_pkg.sv
// Shared types and constants for the fixed-block free-list allocator.
// Used by fbfl_core and fixed_block_free_list_allocator; no dependencies.
package fbfl_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  COUNT_SAT   = {CNT_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(64);
  localparam logic [ADDR_W-1:0] BASE_RESET  = '0;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_IDX = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] block_index;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_count;
    logic              has_free;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] block_size;
    logic [CNT_W-1:0]  block_count;
  } cfg_t;

  // Pool size clipped to the link store depth.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    return (cnt > COUNT_RESET) ? COUNT_RESET : cnt;
  endfunction

endpackage

// File: rtl/fbfl_core.sv
// Free-list state, link store and per-item result logic.
// Depends on fbfl_pkg.
module fbfl_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fbfl_pkg::cfg_t  cfg_i,
  input  logic            init_i,
  input  logic [10:0]     init_count_i,
  input  logic            accept_i,
  input  fbfl_pkg::item_t item_i,
  output fbfl_pkg::result_t res_o
);
  import fbfl_pkg::*;

  logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
  logic [CNT_W-1:0] rd_data_q;

  logic [CNT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] next_q, next_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] bump_q, bump_d;
  logic [CNT_W-1:0] free_q, free_d;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [CNT_W-1:0] wr_data;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  next_eff;
  logic [CNT_W-1:0]  head_m1;
  logic [1:0]        status;
  logic [IDX_W-1:0]  gidx;
  logic              grant;
  logic [25:0]       prod;

  assign n_eff    = eff_count(cfg_i.block_count);
  // Link of the current head: fresh from the store right after a pop.
  assign next_eff = pend_q ? rd_data_q : next_q;
  assign head_m1  = head_q - CNT_W'(1);

  always_comb begin
    head_d  = head_q;
    next_d  = next_q;
    pend_d  = pend_q;
    bump_d  = bump_q;
    free_d  = free_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    status  = ST_OK;
    gidx    = '0;
    grant   = 1'b0;
    if (accept_i) begin
      case (item_i.action)
        ACT_ALLOC: begin
          if (head_q != '0) begin
            // Pop the head and prefetch the link of the new head.
            gidx   = head_m1[IDX_W-1:0];
            grant  = 1'b1;
            head_d = next_eff;
            if (next_eff != '0) begin
              rd_en   = 1'b1;
              rd_addr = IDX_W'(next_eff - CNT_W'(1));
              pend_d  = 1'b1;
            end else begin
              pend_d = 1'b0;
            end
          end else if (bump_q < n_eff) begin
            gidx   = bump_q[IDX_W-1:0];
            grant  = 1'b1;
            bump_d = bump_q + CNT_W'(1);
          end else begin
            status = ST_EMPTY;
          end
          if (grant && free_q != '0) begin
            free_d = free_q - CNT_W'(1);
          end
        end
        ACT_FREE: begin
          if ({1'b0, item_i.block_index} >= n_eff) begin
            status = ST_BAD_IDX;
          end else begin
            wr_en   = 1'b1;
            wr_addr = item_i.block_index;
            wr_data = head_q;
            head_d  = {1'b0, item_i.block_index} + CNT_W'(1);
            next_d  = head_q;
            pend_d  = 1'b0;
            if (free_q != COUNT_SAT) begin
              free_d = free_q + CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign prod = gidx * cfg_i.block_size;

  always_comb begin
    res_o                 = '0;
    res_o.status          = status;
    res_o.granted_index   = gidx;
    res_o.granted_address = grant ? (cfg_i.base_address + ADDR_W'(prod)) : '0;
    res_o.free_count      = free_d;
    res_o.has_free        = (free_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      next_q <= '0;
      pend_q <= 1'b0;
      bump_q <= '0;
      free_q <= COUNT_RESET;
    end else if (init_i) begin
      head_q <= '0;
      next_q <= '0;
      pend_q <= 1'b0;
      bump_q <= '0;
      free_q <= eff_count(init_count_i);
    end else begin
      head_q <= head_d;
      next_q <= next_d;
      pend_q <= pend_d;
      bump_q <= bump_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= link_mem[rd_addr];
    end
  end

endmodule

// File: rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed-block free-list allocator: configuration registers,
// result register and handshakes. Depends on fbfl_pkg and fbfl_core.
//
//   port group   direction  handshake           payload
//   in_*         in         in_valid_i/in_stall_o   item_t (action, block_index)
//   out_*        out        out_valid_o/out_stall_i result_t
//   cfg_*        in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; the result shows in the cycle after acceptance.
// A pop reads the link store for the new head's link, and the registered
// read data is bypassed straight into the next pop, so pops run back to back.
// Reset loads the default configuration and an empty list; no clearing pass.
// in_stall_o is high while the result register holds an item that is stalled.
module fixed_block_free_list_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fbfl_pkg::item_t   in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fbfl_pkg::result_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import fbfl_pkg::*;

  cfg_t    cfg_q;
  logic    out_valid_q;
  result_t out_item_q;
  result_t res;
  logic    in_accept;
  logic    init;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign init       = cfg_we_i && (cfg_idx_i == REG_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address <= BASE_RESET;
      cfg_q.block_size   <= SIZE_RESET;
      cfg_q.block_count  <= COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE:  cfg_q.base_address <= cfg_data_i[ADDR_W-1:0];
        REG_SIZE:  cfg_q.block_size   <= cfg_data_i[SIZE_W-1:0];
        REG_COUNT: cfg_q.block_count  <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fbfl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .init_i       (init),
    .init_count_i (cfg_data_i[CNT_W-1:0]),
    .accept_i     (in_accept),
    .item_i       (in_item_i),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result only with a new item; hold it otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !(out_valid_q && out_stall_i))
    else $error("item accepted while stalled result pending");

  a_grant_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_item_i.action == ACT_ALLOC && res.status == ST_OK)
      |-> ({1'b0, res.granted_index} < eff_count(cfg_q.block_count)))
    else $error("granted block outside pool");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept))
    else $error("result without accepted item");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for fixed_block_free_list_allocator: directed and random
// allocate, free and query items, checked against a free-list model kept in this file.
// Depends on fbfl_pkg and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbfl_pkg::*;

  localparam int PLAN = 0;
  localparam int LIVE = 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused code, behaves as a query

  typedef struct packed {
    item_t req;
    logic  wait_idle;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  item_t       in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  // Configuration as the block sees it
  logic [ADDR_W-1:0] cfg_base = BASE_RESET;
  logic [SIZE_W-1:0] cfg_size = SIZE_RESET;
  logic [CNT_W-1:0]  cfg_count = COUNT_RESET;

  // Two copies of the pool: one run ahead while planning items, one at acceptance
  logic [CNT_W-1:0] pool_links [2][MAX_BLOCKS];
  logic [CNT_W-1:0] pool_head [2];
  logic [CNT_W-1:0] pool_bump [2];
  logic [CNT_W-1:0] pool_free [2];

  pending_t         req_queue[$];
  result_t          due_results[$];
  logic [IDX_W-1:0] held_blocks[$];

  int   mismatches = 0;
  int   cycles = 0;
  int   taken_count = 0;
  logic item_taken = 1'b0;
  logic steady;

  assign steady = (taken_count >= 600) && (taken_count < 1000);

  fixed_block_free_list_allocator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] pool_size();
    return (cfg_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_count;
  endfunction

  function automatic void reset_pools();
    for (int p = 0; p < 2; p++) begin
      pool_head[p] = '0;
      pool_bump[p] = '0;
      pool_free[p] = pool_size();
    end
  endfunction

  // Apply one item to pool copy p and return the result it produces.
  function automatic result_t serve_item(input int p, input item_t it);
    result_t          r;
    logic [IDX_W-1:0] g;
    logic [CNT_W-1:0] n;
    logic             granted;
    r = '0;
    g = '0;
    granted = 1'b0;
    n = pool_size();
    case (it.action)
      ACT_ALLOC: begin
        // pop the most recently freed block, else take a never-used one
        if (pool_head[p] != '0) begin
          g = IDX_W'(pool_head[p] - 1'b1);
          pool_head[p] = pool_links[p][g];
          granted = 1'b1;
        end else if (pool_bump[p] < n) begin
          g = IDX_W'(pool_bump[p]);
          pool_bump[p] = pool_bump[p] + 1'b1;
          granted = 1'b1;
        end
        if (granted) begin
          if (pool_free[p] != '0) pool_free[p] = pool_free[p] - 1'b1;
          r.granted_index = g;
          r.granted_address = cfg_base + ADDR_W'(g) * ADDR_W'(cfg_size);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_FREE: begin
        if (CNT_W'(it.block_index) >= n) begin
          r.status = ST_BAD_IDX;
        end else begin
          pool_links[p][it.block_index] = pool_head[p];
          pool_head[p] = CNT_W'(it.block_index) + 1'b1;
          if (pool_free[p] != COUNT_SAT) pool_free[p] = pool_free[p] + 1'b1;
        end
      end
      default: ;
    endcase
    r.free_count = pool_free[p];
    r.has_free = (pool_free[p] != '0);
    return r;
  endfunction

  // Queue an item and track which blocks it leaves allocated.
  function automatic void plan_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                                    input logic hold);
    pending_t e;
    result_t  r;
    e.req.action = act;
    e.req.block_index = idx;
    e.wait_idle = hold;
    r = serve_item(PLAN, e.req);
    if (act == ACT_ALLOC && r.status == ST_OK) held_blocks.push_back(r.granted_index);
    if (act == ACT_FREE && r.status == ST_OK) begin
      for (int k = 0; k < held_blocks.size(); k++) begin
        if (held_blocks[k] == idx) begin
          held_blocks.delete(k);
          break;
        end
      end
    end
    req_queue.push_back(e);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input reg_idx_e r, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_BASE: cfg_base = v;
      REG_SIZE: cfg_size = v[SIZE_W-1:0];
      REG_COUNT: begin
        cfg_count = v[CNT_W-1:0];
        reset_pools();
        held_blocks.delete();
      end
      default: ;
    endcase
  endtask

  // Hold until every planned item is in and every result is out.
  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (req_queue.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input logic [31:0] base, input logic [SIZE_W-1:0] size,
                              input logic [CNT_W-1:0] count, input int n_items,
                              input int alloc_pct);
    int   roll;
    logic hold;
    write_reg(REG_BASE, base);
    write_reg(REG_SIZE, 32'(size));
    write_reg(REG_COUNT, 32'(count));
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      hold = (i % 150 == 75);
      if (roll < 12) begin
        case ($urandom_range(3))
          0: plan_item(ACT_QUERY, IDX_W'($urandom), hold);
          1: plan_item(ACT_SPARE, IDX_W'($urandom), hold);
          2: plan_item(ACT_FREE, IDX_W'($urandom), hold);
          // first index past the pool (wraps to index 0 when the pool holds MAX_BLOCKS)
          default: plan_item(ACT_FREE, IDX_W'(pool_size()), hold);
        endcase
      end else if (held_blocks.size() == 0 || roll < 12 + alloc_pct) begin
        plan_item(ACT_ALLOC, IDX_W'($urandom), hold);
      end else begin
        plan_item(ACT_FREE, held_blocks[$urandom_range(held_blocks.size() - 1)], hold);
      end
    end
    wait_quiet();
  endtask

  // Driver: present the next item once the current one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || item_taken) begin
        if (req_queue.size() != 0 && !(req_queue[0].wait_idle && due_results.size() != 0)
            && (steady || $urandom_range(99) >= 26)) begin
          in_item <= req_queue[0].req;
          in_valid <= 1'b1;
          void'(req_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 26);
    end
  end

  // Monitor: check results against the oldest expectation, then predict new items.
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("fixed_block_free_list_allocator test failed");
      $finish;
    end else begin
      item_taken = rst_n && in_valid && !in_stall;
      if (rst_n && out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, out_item);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("granted_index", 32'(want.granted_index), 32'(out_item.granted_index));
          check_field("granted_address", want.granted_address, out_item.granted_address);
          check_field("free_count", 32'(want.free_count), 32'(out_item.free_count));
          check_field("has_free", 32'(want.has_free), 32'(out_item.has_free));
        end
      end
      if (item_taken) begin
        due_results.push_back(serve_item(LIVE, in_item));
        taken_count++;
      end
    end
  end

  initial begin
    reset_pools();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: bump grants, LIFO pops, top index, spare action code
    plan_item(ACT_QUERY, '1, 1'b0);
    plan_item(ACT_ALLOC, '0, 1'b0);
    plan_item(ACT_ALLOC, '1, 1'b0);
    plan_item(ACT_FREE, IDX_W'(1), 1'b0);
    plan_item(ACT_FREE, IDX_W'(0), 1'b0);
    plan_item(ACT_ALLOC, '0, 1'b0);
    plan_item(ACT_ALLOC, '0, 1'b0);
    plan_item(ACT_ALLOC, '0, 1'b0);
    plan_item(ACT_FREE, '1, 1'b0);
    plan_item(ACT_SPARE, '1, 1'b0);
    wait_quiet();

    // Three blocks near the top of the address space: wrap, exhaustion,
    // out-of-range frees, double free and free count underflow
    write_reg(REG_BASE, 32'hFFFF_FFF0);
    write_reg(REG_SIZE, 32'h0000_FFFF);
    write_reg(REG_COUNT, 32'd3);
    repeat (4) plan_item(ACT_ALLOC, '0, 1'b0);
    plan_item(ACT_FREE, IDX_W'(3), 1'b0);
    plan_item(ACT_FREE, '1, 1'b0);
    plan_item(ACT_FREE, IDX_W'(2), 1'b0);
    plan_item(ACT_FREE, IDX_W'(2), 1'b0);
    repeat (3) plan_item(ACT_ALLOC, '0, 1'b0);
    wait_quiet();

    // Empty pool
    write_reg(REG_COUNT, 32'd0);
    plan_item(ACT_ALLOC, '0, 1'b0);
    plan_item(ACT_FREE, '0, 1'b0);
    plan_item(ACT_QUERY, '0, 1'b0);
    wait_quiet();

    random_phase($urandom, 16'd1, 11'd1, 30, 45);
    random_phase(32'hFFFF_FFFF, 16'hFFFF, 11'd1024, 30, 50);
    random_phase($urandom, SIZE_W'($urandom_range(65535, 1)), 11'd2047, 30, 50);
    random_phase(32'h0, SIZE_W'($urandom_range(65535, 1)), 11'd5, 30, 45);
    random_phase($urandom, SIZE_W'($urandom_range(65535, 1)), 11'd16, 30, 48);
    random_phase($urandom, SIZE_W'($urandom_range(65535, 1)), 11'd64, 35, 52);
    random_phase($urandom, SIZE_W'($urandom_range(65535, 1)), 11'd3, 30, 70);
    random_phase($urandom, SIZE_W'($urandom_range(65535, 1)),
                 CNT_W'($urandom_range(40, 1)), 30, 48);

    // Repeated frees on a full pool drive the free count into saturation
    write_reg(REG_COUNT, 32'd1024);
    for (int i = 0; i < 1060; i++) begin
      plan_item((i % 50 == 0) ? ACT_QUERY : ACT_FREE, IDX_W'($urandom_range(1023)), i == 500);
    end
    repeat (20) plan_item(ACT_ALLOC, IDX_W'($urandom), 1'b0);
    wait_quiet();

    if (mismatches == 0) begin
      $display("fixed_block_free_list_allocator test passed");
    end else begin
      $display("fixed_block_free_list_allocator test failed");
    end
    $finish;
  end

endmodule
